@@ hdl/cave_automaton_generation_unit_macros.svh @@
// Assertion macros used by the cave automaton generation top level.
`ifndef CAVE_AUTOMATON_GENERATION_UNIT_MACROS_SVH
`define CAVE_AUTOMATON_GENERATION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAG_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CAG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cag_pkg.sv @@
// Shared types and constants of the cave automaton generation unit.
package cag_pkg;

  // Fixed field widths
  localparam int unsigned LINE_W      = 64;
  localparam int unsigned CNT_REG_W   = 13;
  localparam int unsigned LEN_REG_W   = 7;
  localparam int unsigned NUM_W       = 12;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;

  // Parameter defaults
  localparam int unsigned MAX_LINE_LEN_DEF = 64;
  localparam int unsigned MAX_LINES_DEF    = 4096;

  // Grid rules
  localparam int unsigned MIN_LINES   = 6;
  localparam int unsigned MIN_LEN     = 6;
  localparam int unsigned EDGE_CELLS  = 3;  // rows/cells below this index, and the last two, pass through
  localparam int unsigned KEEP_MIN    = 4;  // wall stays wall at this many wall neighbors
  localparam int unsigned BORN_MIN    = 5;  // open turns wall at this many wall neighbors

  // Register map, word index taken from paddr[2]
  typedef enum logic [0:0] {
    REG_LINE_COUNT  = 1'b0,
    REG_LINE_LENGTH = 1'b1
  } cfg_reg_e;

  // Per-row control handed to the lane array
  typedef struct packed {
    logic                 inner;  // row lies inside the interior band
    logic [LEN_REG_W-1:0] len;    // effective line length
    logic [LINE_W-1:0]    mask;   // cells below len
  } row_ctrl_t;

  // One result beat
  typedef struct packed {
    logic [LINE_W-1:0] cells;
    logic [NUM_W-1:0]  num;
    logic              last;
    logic              done;
  } res_t;

endpackage

@@ hdl/cag_cell.sv @@
// One lane: neighbor count and 4-5 rule for a single cell.
module cag_cell (
  input  logic [2:0] above_i,    // cells y-1, y, y+1 of the line above
  input  logic [2:0] cur_i,      // cells y-1, y, y+1 of this line
  input  logic [2:0] below_i,    // cells y-1, y, y+1 of the line below
  input  logic       interior_i,
  output logic       cell_o
);

  logic [3:0] nbr_cnt;

  // Eight-neighbor wall count
  always_comb begin
    nbr_cnt = 4'(above_i[0]) + 4'(above_i[1]) + 4'(above_i[2])
            + 4'(below_i[0]) + 4'(below_i[1]) + 4'(below_i[2])
            + 4'(cur_i[0])   + 4'(cur_i[2]);
  end

  // Rule, or pass-through outside the interior
  always_comb begin
    if (!interior_i) begin
      cell_o = cur_i[1];
    end else if (cur_i[1]) begin
      cell_o = (nbr_cnt >= 4'(cag_pkg::KEEP_MIN));
    end else begin
      cell_o = (nbr_cnt >= 4'(cag_pkg::BORN_MIN));
    end
  end

endmodule

@@ hdl/cag_row.sv @@
// Lane array for one line plus merge of the lane bits into the new line.
module cag_row #(
  parameter int unsigned MAX_LINE_LEN = cag_pkg::MAX_LINE_LEN_DEF
) (
  input  logic [cag_pkg::LINE_W-1:0] above_i,
  input  logic [cag_pkg::LINE_W-1:0] cur_i,
  input  logic [cag_pkg::LINE_W-1:0] below_i,
  input  cag_pkg::row_ctrl_t         ctrl_i,
  output logic [cag_pkg::LINE_W-1:0] line_o
);

  logic [cag_pkg::LINE_W-1:0] lane_bits;

  for (genvar y = 0; y < cag_pkg::LINE_W; y++) begin : g_lane
    if (y < MAX_LINE_LEN) begin : g_cell
      logic [2:0] a_win, c_win, b_win;
      logic       cell_in;

      // Neighbor windows, zero past the line ends
      if (y == 0) begin : g_lo
        assign a_win[0] = 1'b0;
        assign c_win[0] = 1'b0;
        assign b_win[0] = 1'b0;
      end else begin : g_lo_n
        assign a_win[0] = above_i[y-1];
        assign c_win[0] = cur_i[y-1];
        assign b_win[0] = below_i[y-1];
      end
      assign a_win[1] = above_i[y];
      assign c_win[1] = cur_i[y];
      assign b_win[1] = below_i[y];
      if (y == cag_pkg::LINE_W - 1) begin : g_hi
        assign a_win[2] = 1'b0;
        assign c_win[2] = 1'b0;
        assign b_win[2] = 1'b0;
      end else begin : g_hi_n
        assign a_win[2] = above_i[y+1];
        assign c_win[2] = cur_i[y+1];
        assign b_win[2] = below_i[y+1];
      end

      // Cell is interior when 3 <= y <= len-3 and the row is interior
      assign cell_in = ctrl_i.inner && (y >= cag_pkg::EDGE_CELLS) &&
                       (cag_pkg::LEN_REG_W'(y + cag_pkg::EDGE_CELLS) <= ctrl_i.len);

      cag_cell u_cell (
        .above_i    (a_win),
        .cur_i      (c_win),
        .below_i    (b_win),
        .interior_i (cell_in),
        .cell_o     (lane_bits[y])
      );
    end else begin : g_none
      assign lane_bits[y] = 1'b0;
    end
  end

  // Merge: cells past the line length read as open
  assign line_o = lane_bits & ctrl_i.mask;

endmodule

@@ hdl/cave_automaton_generation_unit.sv @@
// Top level of the cave automaton generation unit (one 4-5 smoothing generation).
//
// Usage: the grid streams in one line per input beat on line_cells_i (bit i set
// = wall), under a valid/ready handshake. Results leave on the output channel
// one line late: the first line of a grid gives no beat, each further line
// gives the updated previous line, and the grid's last line gives two beats
// (the line before it, then itself, with grid_done_o set on the second).
// run_last_o marks the last beat caused by an input beat.
// Latency: a result beat is presented in the cycle after the input beat that
// completes it. Throughput: one line per cycle while out_ready_i is high; the grid's
// last line stalls the input until its second beat leaves the one-entry hold register.
// All 64 neighbor counters of a line work in parallel lanes, two rows of lanes
// (the flushed row and the final row) evaluated at once.
// Stall: while out_ready_i is low the result register holds, and in_ready_o
// drops when no room is left for the next beat.
// Reset: line_count and line_length return to 64, stored lines clear and the line
// counter restarts at zero. The user must write the registers over the APB port
// (line_count at 0x0, line_length at 0x4) only while the block is idle; not enforced.
module cave_automaton_generation_unit #(
  parameter int unsigned MAX_LINE_LEN = cag_pkg::MAX_LINE_LEN_DEF,
  parameter int unsigned MAX_LINES    = cag_pkg::MAX_LINES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cag_pkg::ADDR_W-1:0]    paddr,
  input  logic [cag_pkg::DATA_W-1:0]    pwdata,
  output logic [cag_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  // Input lines
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cag_pkg::LINE_W-1:0]    line_cells_i,
  // Result lines
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cag_pkg::LINE_W-1:0]    new_line_cells_o,
  output logic [cag_pkg::NUM_W-1:0]     line_number_o,
  output logic                          run_last_o,
  output logic                          grid_done_o
);

`include "cave_automaton_generation_unit_macros.svh"

  localparam int unsigned CntW = $clog2(MAX_LINES + 1);
  localparam int unsigned IdxW = $clog2(MAX_LINES);
  localparam int unsigned CmpW = (CntW > cag_pkg::CNT_REG_W) ? CntW : cag_pkg::CNT_REG_W;

  // Configuration registers
  logic [cag_pkg::CNT_REG_W-1:0] line_count_q;
  logic [cag_pkg::LEN_REG_W-1:0] line_length_q;
  logic                          cfg_wr;
  cag_pkg::cfg_reg_e             cfg_sel;

  // Line state
  logic [cag_pkg::LINE_W-1:0] prev_old_q, prev_old_d;
  logic [cag_pkg::LINE_W-1:0] prev_new_q, prev_new_d;
  logic [IdxW-1:0]            idx_q, idx_d;

  // Output stage: result register plus one hold entry
  cag_pkg::res_t out_q, out_d, pend_q, pend_d;
  logic          out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;

  // Datapath
  logic [CmpW-1:0]                cnt_raw;
  logic [CntW-1:0]                cnt_eff;
  logic [cag_pkg::LEN_REG_W-1:0]  len_eff;
  logic [cag_pkg::LINE_W-1:0]     len_mask;
  logic [cag_pkg::LINE_W-1:0]     line_m, older_m, newer_m;
  logic [CntW-1:0]                row_a, row_b;
  logic                           is_last, in_fire, out_free;
  cag_pkg::row_ctrl_t             ctrl_a, ctrl_b;
  logic [cag_pkg::LINE_W-1:0]     line_a, line_b;

  // APB access
  assign pready  = 1'b1;
  assign cfg_sel = cag_pkg::cfg_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q  <= cag_pkg::CNT_REG_W'(64);
      line_length_q <= cag_pkg::LEN_REG_W'(64);
    end else if (cfg_wr) begin
      case (cfg_sel)
        cag_pkg::REG_LINE_COUNT:  line_count_q  <= pwdata[cag_pkg::CNT_REG_W-1:0];
        cag_pkg::REG_LINE_LENGTH: line_length_q <= pwdata[cag_pkg::LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      cag_pkg::REG_LINE_COUNT:  prdata = cag_pkg::DATA_W'(line_count_q);
      cag_pkg::REG_LINE_LENGTH: prdata = cag_pkg::DATA_W'(line_length_q);
      default:                  prdata = '0;
    endcase
  end

  // Effective grid size, saturated into the supported range
  always_comb begin
    cnt_raw = CmpW'(line_count_q);
    if (cnt_raw < CmpW'(cag_pkg::MIN_LINES)) begin
      cnt_eff = CntW'(cag_pkg::MIN_LINES);
    end else if (cnt_raw > CmpW'(MAX_LINES)) begin
      cnt_eff = CntW'(MAX_LINES);
    end else begin
      cnt_eff = CntW'(cnt_raw);
    end

    if (line_length_q < cag_pkg::LEN_REG_W'(cag_pkg::MIN_LEN)) begin
      len_eff = cag_pkg::LEN_REG_W'(cag_pkg::MIN_LEN);
    end else if (line_length_q > cag_pkg::LEN_REG_W'(MAX_LINE_LEN)) begin
      len_eff = cag_pkg::LEN_REG_W'(MAX_LINE_LEN);
    end else begin
      len_eff = line_length_q;
    end

    for (int i = 0; i < cag_pkg::LINE_W; i++) begin
      len_mask[i] = (cag_pkg::LEN_REG_W'(i) < len_eff);
    end
  end

  // Masked lines and row positions
  assign line_m  = line_cells_i & len_mask;
  assign older_m = prev_old_q & len_mask;
  assign newer_m = prev_new_q & len_mask;
  assign row_b   = CntW'(idx_q);
  assign row_a   = row_b - CntW'(1);
  assign is_last = (row_b + CntW'(1)) >= cnt_eff;

  always_comb begin
    ctrl_a.inner = (row_a >= CntW'(cag_pkg::EDGE_CELLS)) &&
                   (row_a <= cnt_eff - CntW'(cag_pkg::EDGE_CELLS));
    ctrl_a.len   = len_eff;
    ctrl_a.mask  = len_mask;
    ctrl_b.inner = (row_b >= CntW'(cag_pkg::EDGE_CELLS)) &&
                   (row_b <= cnt_eff - CntW'(cag_pkg::EDGE_CELLS));
    ctrl_b.len   = len_eff;
    ctrl_b.mask  = len_mask;
  end

  // Row emitted one line late
  cag_row #(.MAX_LINE_LEN(MAX_LINE_LEN)) u_row_a (
    .above_i (older_m),
    .cur_i   (newer_m),
    .below_i (line_m),
    .ctrl_i  (ctrl_a),
    .line_o  (line_a)
  );

  // Final row of a grid, open line below
  cag_row #(.MAX_LINE_LEN(MAX_LINE_LEN)) u_row_b (
    .above_i (newer_m),
    .cur_i   (line_m),
    .below_i ('0),
    .ctrl_i  (ctrl_b),
    .line_o  (line_b)
  );

  // Handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !pend_valid_q && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // Next state of line store and output stage
  always_comb begin
    prev_old_d   = prev_old_q;
    prev_new_d   = prev_new_q;
    idx_d        = idx_q;
    out_d        = out_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    pend_valid_d = pend_valid_q;

    if (pend_valid_q) begin
      // drain the held second beat
      if (out_ready_i) begin
        out_d        = pend_q;
        pend_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      out_d.cells = line_a;
      out_d.num   = cag_pkg::NUM_W'(idx_q - IdxW'(1));
      out_d.done  = 1'b0;
      if (is_last) begin
        out_d.last   = 1'b0;
        pend_d.cells = line_b;
        pend_d.num   = cag_pkg::NUM_W'(idx_q);
        pend_d.last  = 1'b1;
        pend_d.done  = 1'b1;
        out_valid_d  = 1'b1;
        pend_valid_d = 1'b1;
        prev_old_d   = '0;
        prev_new_d   = '0;
        idx_d        = '0;
      end else begin
        out_d.last   = 1'b1;
        out_valid_d  = (idx_q != '0);
        prev_old_d   = newer_m;
        prev_new_d   = line_m;
        idx_d        = idx_q + IdxW'(1);
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_old_q   <= '0;
      prev_new_q   <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      prev_old_q   <= prev_old_d;
      prev_new_q   <= prev_new_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o      = out_valid_q;
  assign new_line_cells_o = out_q.cells;
  assign line_number_o    = out_q.num;
  assign run_last_o       = out_q.last;
  assign grid_done_o      = out_q.done;

  // Checks
  `CAG_ASSERT_IMPL(a_pend_needs_out, clk_i, rst_ni, pend_valid_q, out_valid_q, "held beat without result")
  `CAG_ASSERT_IMPL(a_pend_blocks_in, clk_i, rst_ni, pend_valid_q, !in_ready_o, "input taken while beat held")
  `CAG_ASSERT_NEXT(a_pend_is_final, clk_i, rst_ni, pend_valid_q && out_ready_i, out_valid_q && out_q.last && out_q.done, "drained beat not grid end")
  `CAG_ASSERT_NEXT(a_first_line_silent, clk_i, rst_ni, in_fire && (idx_q == '0) && !is_last, !out_valid_q && (idx_q != '0), "first line gave a beat")

endmodule

@@ bench/cave_automaton_generation_unit_tb.sv @@
// Self-checking bench for the cave automaton generation unit: directed grids, then random grids.
`timescale 1ns / 100ps

module cave_automaton_generation_unit_tb;

  // Rule constants of the smoothing step, kept apart from the design
  localparam int unsigned RIM        = 3;     // lines/cells below this index, and the last two, pass through
  localparam int unsigned KEEP_WALL  = 4;     // wall stays wall at this many wall neighbors
  localparam int unsigned GROW_WALL  = 5;     // open turns wall at this many wall neighbors
  localparam int unsigned FLOOR_SIZE = 6;
  localparam int unsigned TOP_LEN    = 64;
  localparam int unsigned TOP_ROWS   = 4096;
  localparam int unsigned RAND_LINES_PER_MODE = 165;

  localparam logic [63:0] ALL_WALL = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ROW_LINE,
    ROW_SET_COUNT,
    ROW_SET_LENGTH
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [63:0] value;
    logic        has_exp;
    logic [63:0] exp_cells;
  } stim_row_t;

  // Directed grids: saturated small sizes, a shrunken oversized grid, full width
  localparam int unsigned N_DIRECTED = 29;
  localparam stim_row_t DIRECTED [0:N_DIRECTED-1] = '{
    // count 0 and length 0 saturate to 6; solid wall keeps its 6 cells
    '{ROW_SET_COUNT,  64'd0,    1'b0, 64'd0},
    '{ROW_SET_LENGTH, 64'd0,    1'b0, 64'd0},
    '{ROW_LINE, ALL_WALL, 1'b1, 64'h3F},
    '{ROW_LINE, ALL_WALL, 1'b1, 64'h3F},
    '{ROW_LINE, ALL_WALL, 1'b1, 64'h3F},
    '{ROW_LINE, ALL_WALL, 1'b1, 64'h3F},
    '{ROW_LINE, ALL_WALL, 1'b1, 64'h3F},
    '{ROW_LINE, ALL_WALL, 1'b1, 64'h3F},
    // count 8191 saturates to 4096, length 127 to 64; cut short below
    '{ROW_SET_COUNT,  64'h1FFF, 1'b0, 64'd0},
    '{ROW_SET_LENGTH, 64'h7F,   1'b0, 64'd0},
    '{ROW_LINE, 64'h0,                   1'b0, 64'd0},
    '{ROW_LINE, ALL_WALL,                1'b1, 64'd0},
    '{ROW_LINE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0},
    '{ROW_LINE, 64'h5555_5555_5555_5555, 1'b0, 64'd0},
    '{ROW_LINE, 64'h0123_4567_89AB_CDEF, 1'b0, 64'd0},
    '{ROW_LINE, 64'hFEDC_BA98_7654_3210, 1'b0, 64'd0},
    '{ROW_LINE, 64'h8000_0000_0000_0001, 1'b0, 64'd0},
    '{ROW_LINE, 64'hF0F0_0F0F_FF00_00FF, 1'b0, 64'd0},
    // shrinking the count mid-grid makes the next line the last one
    '{ROW_SET_COUNT,  64'd6,    1'b0, 64'd0},
    '{ROW_LINE, 64'hDEAD_BEEF_0BAD_F00D, 1'b0, 64'd0},
    // length 65 saturates to 64: full-width solid wall
    '{ROW_SET_COUNT,  64'd7,    1'b0, 64'd0},
    '{ROW_SET_LENGTH, 64'd65,   1'b0, 64'd0},
    '{ROW_LINE, ALL_WALL, 1'b1, ALL_WALL},
    '{ROW_LINE, ALL_WALL, 1'b1, ALL_WALL},
    '{ROW_LINE, ALL_WALL, 1'b1, ALL_WALL},
    '{ROW_LINE, ALL_WALL, 1'b1, ALL_WALL},
    '{ROW_LINE, ALL_WALL, 1'b1, ALL_WALL},
    '{ROW_LINE, ALL_WALL, 1'b1, ALL_WALL},
    '{ROW_LINE, ALL_WALL, 1'b1, ALL_WALL}
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [cag_pkg::ADDR_W-1:0] paddr = '0;
  logic [cag_pkg::DATA_W-1:0] pwdata = '0;
  logic [cag_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  logic                       in_valid = 1'b0;
  logic                       in_ready_o;
  logic [cag_pkg::LINE_W-1:0] line_cells = '0;
  logic                       out_valid_o;
  logic                       out_ready = 1'b0;
  logic [cag_pkg::LINE_W-1:0] new_line_cells_o;
  logic [cag_pkg::NUM_W-1:0]  line_number_o;
  logic                       run_last_o;
  logic                       grid_done_o;

  // Predictor state: registers and the two held lines
  logic [12:0]       cfg_count = 13'd64;
  logic [6:0]        cfg_len = 7'd64;
  logic [63:0]       held_older = '0;
  logic [63:0]       held_newer = '0;
  int unsigned       rows_seen = 0;

  cag_pkg::res_t     pending_lines[$];
  int unsigned       send_idle_pct = 29;
  int unsigned       recv_idle_pct = 68;
  int unsigned       fail_count = 0;
  int unsigned       lines_sent = 0;
  int unsigned       beats_checked = 0;
  int unsigned       grids_closed = 0;
  int unsigned       cfg_writes = 0;

  cave_automaton_generation_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .line_cells_i     (line_cells),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .new_line_cells_o (new_line_cells_o),
    .line_number_o    (line_number_o),
    .run_last_o       (run_last_o),
    .grid_done_o      (grid_done_o)
  );

  always #5 clk_i = ~clk_i;

  // One smoothing step for line r from its neighbors above and below
  function automatic logic [63:0] smooth_row(input logic [63:0] above, input logic [63:0] cur,
                                             input logic [63:0] below, input int unsigned r,
                                             input int unsigned cnt, input int unsigned len);
    logic [63:0] res;
    int unsigned walls;
    res = cur;
    if (r < RIM || r > cnt - RIM) return res;
    for (int unsigned y = RIM; y + RIM <= len; y++) begin
      walls = above[y-1] + above[y] + above[y+1] + below[y-1] + below[y] + below[y+1]
            + cur[y-1] + cur[y+1];
      res[y] = cur[y] ? (walls >= KEEP_WALL) : (walls >= GROW_WALL);
    end
    return res;
  endfunction

  function automatic void queue_line(input logic [63:0] cells, input int unsigned num,
                                     input logic last, input logic done,
                                     input logic has_exp, input logic [63:0] exp_cells);
    cag_pkg::res_t r;
    r.cells = has_exp ? exp_cells : cells;
    r.num   = num[cag_pkg::NUM_W-1:0];
    r.last  = last;
    r.done  = done;
    pending_lines = {pending_lines, r};
  endfunction

  // Take one accepted line into the grid and queue the lines it releases
  function automatic void advance_grid(input logic [63:0] cells, input logic has_exp,
                                       input logic [63:0] exp_cells);
    int unsigned cnt, len, idx;
    logic [63:0] mask, cur, older, newer;
    cnt = (cfg_count < FLOOR_SIZE) ? FLOOR_SIZE : (cfg_count > TOP_ROWS) ? TOP_ROWS : cfg_count;
    len = (cfg_len < FLOOR_SIZE) ? FLOOR_SIZE : (cfg_len > TOP_LEN) ? TOP_LEN : cfg_len;
    mask = (len >= 64) ? ALL_WALL : ((64'd1 << len) - 64'd1);
    cur = cells & mask;
    older = held_older & mask;
    newer = held_newer & mask;
    idx = rows_seen;
    if (idx + 1 >= cnt) begin
      // last line: flush the held line and this one, then start over
      queue_line(smooth_row(older, newer, cur, idx - 1, cnt, len) & mask, idx - 1,
                 1'b0, 1'b0, has_exp, exp_cells);
      queue_line(smooth_row(newer, cur, 64'd0, idx, cnt, len) & mask, idx,
                 1'b1, 1'b1, has_exp, exp_cells);
      held_older = '0;
      held_newer = '0;
      rows_seen = 0;
      grids_closed++;
    end else begin
      held_older = newer;
      held_newer = cur;
      rows_seen = idx + 1;
      if (idx != 0)
        queue_line(smooth_row(older, newer, cur, idx - 1, cnt, len) & mask, idx - 1,
                   1'b1, 1'b0, has_exp, exp_cells);
    end
  endfunction

  // Random line with a wall density of one quarter, one half or three quarters
  function automatic logic [63:0] rand_cells();
    logic [63:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return a | b;
      1: return a & b;
      default: return a;
    endcase
  endfunction

  // Register value, sometimes with junk above the register's width
  function automatic logic [31:0] with_noise(input int unsigned v, input int unsigned w);
    logic [31:0] d;
    d = ($urandom_range(3) == 0) ? $urandom : 32'd0;
    return (d & ~((32'd1 << w) - 32'd1)) | v;
  endfunction

  task automatic send_line(input logic [63:0] cells, input logic has_exp,
                           input logic [63:0] exp_cells);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    line_cells <= cells;
    do @(posedge clk_i); while (!in_ready_o);
    advance_grid(cells, has_exp, exp_cells);
    lines_sent++;
  endtask

  // Stop sending, let every expected beat arrive, then allow for the hold register
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready; read back afterwards
  task automatic reg_write(input cag_pkg::cfg_reg_e which, input logic [31:0] value);
    logic [31:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (which == cag_pkg::REG_LINE_COUNT) begin
      cfg_count = value[12:0];
      want = {19'd0, value[12:0]};
    end else begin
      cfg_len = value[6:0];
      want = {25'd0, value[6:0]};
    end
    cfg_writes++;
    @(negedge clk_i);
    if (prdata !== want) begin
      $error("prdata: expected %h, got %h", want, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver stalls
  always @(negedge clk_i) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Compare each accepted result beat with the oldest expected line
  always @(posedge clk_i) begin : result_check
    cag_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_lines.size() == 0) begin
        $error("result beat with nothing expected: line_number %0d", line_number_o);
        fail_count++;
      end else begin
        want = pending_lines.pop_front();
        beats_checked++;
        if (new_line_cells_o !== want.cells) begin
          $error("new_line_cells: expected %h, got %h", want.cells, new_line_cells_o);
          fail_count++;
        end
        if (line_number_o !== want.num) begin
          $error("line_number: expected %0d, got %0d", want.num, line_number_o);
          fail_count++;
        end
        if (run_last_o !== want.last) begin
          $error("run_last: expected %b, got %b", want.last, run_last_o);
          fail_count++;
        end
        if (grid_done_o !== want.done) begin
          $error("grid_done: expected %b, got %b", want.done, grid_done_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t   row;
    int unsigned cnt_val, len_val, span, mode_lines, grid_len;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      case (row.kind)
        ROW_SET_COUNT: begin
          drain();
          reg_write(cag_pkg::REG_LINE_COUNT, row.value[31:0]);
        end
        ROW_SET_LENGTH: begin
          drain();
          reg_write(cag_pkg::REG_LINE_LENGTH, row.value[31:0]);
        end
        default: send_line(row.value, row.has_exp, row.exp_cells);
      endcase
    end

    // Random grids under three idling patterns
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 29 : (m == 1) ? 68 : 0;
      recv_idle_pct = (m == 0) ? 68 : (m == 1) ? 29 : 0;
      mode_lines = 0;
      while (mode_lines < RAND_LINES_PER_MODE) begin
        case ($urandom_range(19))
          0: cnt_val = $urandom_range(5);
          1: cnt_val = $urandom_range(4097, 8191);
          default: cnt_val = $urandom_range(6, 14);
        endcase
        case ($urandom_range(9))
          0: len_val = $urandom_range(5);
          1: len_val = $urandom_range(65, 127);
          2: len_val = FLOOR_SIZE;
          3: len_val = TOP_LEN;
          default: len_val = $urandom_range(6, 64);
        endcase
        drain();
        reg_write(cag_pkg::REG_LINE_COUNT, with_noise(cnt_val, 13));
        reg_write(cag_pkg::REG_LINE_LENGTH, with_noise(len_val, 7));
        if (cnt_val > TOP_ROWS) begin
          // oversized grid, cut short by a smaller count mid-grid
          span = $urandom_range(5, 12);
          repeat (span) send_line(rand_cells(), 1'b0, '0);
          drain();
          reg_write(cag_pkg::REG_LINE_COUNT, with_noise($urandom_range(6, span + 1), 13));
          send_line(rand_cells(), 1'b0, '0);
          mode_lines += span + 1;
        end else begin
          grid_len = (cnt_val < FLOOR_SIZE) ? FLOOR_SIZE : cnt_val;
          repeat ($urandom_range(1, 2)) begin
            for (int unsigned k = 0; k < grid_len; k++) begin
              // now and then hold the sender until the output side is empty
              if ($urandom_range(99) == 0) drain();
              send_line(rand_cells(), 1'b0, '0);
              mode_lines++;
            end
          end
        end
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d lines over %0d grids with %0d register writes;", lines_sent,
             grids_closed, cfg_writes);
    $display("checked %0d result beats under three stall patterns.", beats_checked);
    if (fail_count == 0) begin
      $display("cave_automaton_generation_unit_tb: clean");
    end else begin
      $display("cave_automaton_generation_unit_tb: errors");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("cave_automaton_generation_unit_tb: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/cag_pkg.sv
hdl/cag_cell.sv
hdl/cag_row.sv
hdl/cave_automaton_generation_unit.sv
bench/cave_automaton_generation_unit_tb.sv
